>>> hw/rtl/bis_pkg.sv
`default_nettype none

package bis_pkg;

	localparam int OP_W      = 1;
	localparam int INDEX_W   = 16;
	localparam int VALUE_W   = 32;
	localparam int COORD_W   = 17;
	localparam int DIM_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	typedef struct packed {
		logic vld;
		logic sample;
		logic ok;
		logic wr;
	} ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/bis_if.sv
`default_nettype none

interface bis_req_if;
	logic                                valid;
	logic                                ready;
	logic [bis_pkg::OP_W-1:0]            operation;
	logic [bis_pkg::INDEX_W-1:0]         pixel_index;
	logic signed [bis_pkg::VALUE_W-1:0]  pixel_value;
	logic signed [bis_pkg::COORD_W-1:0]  x_coord;
	logic signed [bis_pkg::COORD_W-1:0]  y_coord;

	modport source (output valid, operation, pixel_index, pixel_value, x_coord, y_coord,
		input ready);
	modport sink (input valid, operation, pixel_index, pixel_value, x_coord, y_coord,
		output ready);
endinterface

interface bis_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [bis_pkg::VALUE_W-1:0]  sample_value;
	logic                                sample_valid;

	modport source (output valid, sample_value, sample_valid, input ready);
	modport sink (input valid, sample_value, sample_valid, output ready);
endinterface

interface bis_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bis_pkg::CFG_IDX_W-1:0]      index;
	logic [bis_pkg::DIM_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bilinear_image_sampler.sv
// channel  dir  handshake      payload
// cfg      in   valid/ready    index, data (width_in_use = 0, height_in_use = 1)
// req      in   valid/ready    operation, pixel_index, pixel_value, x_coord, y_coord
// rsp      out  valid/ready    sample_value, sample_valid
//
// One item per cycle, writes and samples alike, while rsp is not stalled; cfg is always ready.
// A sample's result passes through registers s1 to s6 and then leaves the output register.
// Two image copies, each read at two addresses per cycle while the pipeline advances, supply the four neighbors.
// Reset clears control and sets both config registers to 256; image contents stay undefined.
// A result held at rsp stalls the whole pipeline in lockstep.
`default_nettype none

module bilinear_image_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8,
	parameter int PIXEL_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bis_cfg_if.sink   cfg,
	bis_req_if.sink   req,
	bis_rsp_if.source rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WLW   = $clog2(MAX_WIDTH + 1);
	localparam int HLW   = $clog2(MAX_HEIGHT + 1);

	logic [bis_pkg::DIM_W-1:0]          width_q, height_q;
	logic [WLW-1:0]                     wlim;
	logic [HLW-1:0]                     hlim;
	logic                               adv;
	logic                               vld_s1;
	logic [bis_pkg::OP_W-1:0]           op_s1;
	logic [bis_pkg::INDEX_W-1:0]        idx_s1;
	logic signed [bis_pkg::VALUE_W-1:0] value_s1;
	logic signed [bis_pkg::COORD_W-1:0] x_s1, y_s1;
	bis_pkg::ctrl_t                     ctrl_s2;
	logic [FRAC_BITS-1:0]               fx_s2, fy_s2;
	logic [AW-1:0]                      base_s2, widx_s2;
	logic [PIXEL_BITS-1:0]              wdata_s2;
	logic [AW-1:0]                      addr_01, addr_10, addr_11;
	logic                               ram_we;
	logic [PIXEL_BITS-1:0]              rd00, rd01, rd10, rd11;
	logic                               out_vld_q, svalid_q;
	logic signed [bis_pkg::VALUE_W-1:0] value_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bis_pkg::DIM_RESET;
			height_q <= bis_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				bis_pkg::CFG_WIDTH:  width_q  <= cfg.data;
				bis_pkg::CFG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wlim = (32'(width_q) > 32'(MAX_WIDTH)) ? WLW'(MAX_WIDTH) : WLW'(width_q);
		hlim = (32'(height_q) > 32'(MAX_HEIGHT)) ? HLW'(MAX_HEIGHT) : HLW'(height_q);
	end

	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= req.operation;
			idx_s1   <= req.pixel_index;
			value_s1 <= req.pixel_value;
			x_s1     <= req.x_coord;
			y_s1     <= req.y_coord;
		end
	end

	bis_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_s1   (vld_s1),
		.op_s1    (op_s1),
		.idx_s1   (idx_s1),
		.value_s1 (value_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.wlim     (wlim),
		.hlim     (hlim),
		.ctrl_s2  (ctrl_s2),
		.fx_s2    (fx_s2),
		.fy_s2    (fy_s2),
		.base_s2  (base_s2),
		.widx_s2  (widx_s2),
		.wdata_s2 (wdata_s2)
	);

	always_comb begin
		addr_01 = base_s2 + AW'(1);
		addr_10 = base_s2 + AW'(wlim);
		addr_11 = base_s2 + AW'(wlim) + AW'(1);
		ram_we  = adv && ctrl_s2.vld && ctrl_s2.wr;
	end

	bis_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_ram_upper (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (widx_s2),
		.wdata   (wdata_s2),
		.re      (adv),
		.raddr_a (base_s2),
		.raddr_b (addr_01),
		.rdata_a (rd00),
		.rdata_b (rd01)
	);

	bis_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_ram_lower (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (widx_s2),
		.wdata   (wdata_s2),
		.re      (adv),
		.raddr_a (addr_10),
		.raddr_b (addr_11),
		.rdata_a (rd10),
		.rdata_b (rd11)
	);

	bis_blend #(
		.FRAC_BITS  (FRAC_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctrl_s2   (ctrl_s2),
		.fx_s2     (fx_s2),
		.fy_s2     (fy_s2),
		.v00       ($signed(rd00)),
		.v01       ($signed(rd01)),
		.v10       ($signed(rd10)),
		.v11       ($signed(rd11)),
		.out_vld_q (out_vld_q),
		.value_q   (value_q),
		.svalid_q  (svalid_q)
	);

	assign rsp.valid        = out_vld_q;
	assign rsp.sample_value = value_q;
	assign rsp.sample_valid = svalid_q;

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.sample_valid |-> rsp.sample_value == '0)
		else $error("invalid sample carries a nonzero value");

	a_reads_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s2.vld && ctrl_s2.ok |-> (32'(base_s2) + 32'(wlim) + 32'd1) < 32'(DEPTH))
		else $error("in-range sample addresses a pixel beyond the store");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(ctrl_s2) && $stable(base_s2))
		else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

>>> hw/rtl/bis_ram.sv
`default_nettype none

module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bis_addr.sv
`default_nettype none

module bis_addr #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8,
	parameter int PIXEL_BITS = 32,
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = $clog2(DEPTH),
	localparam int WLW   = $clog2(MAX_WIDTH + 1),
	localparam int HLW   = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                vld_s1,
	input  wire logic [bis_pkg::OP_W-1:0]            op_s1,
	input  wire logic [bis_pkg::INDEX_W-1:0]         idx_s1,
	input  wire logic signed [bis_pkg::VALUE_W-1:0]  value_s1,
	input  wire logic signed [bis_pkg::COORD_W-1:0]  x_s1,
	input  wire logic signed [bis_pkg::COORD_W-1:0]  y_s1,
	input  wire logic [WLW-1:0]                      wlim,
	input  wire logic [HLW-1:0]                      hlim,
	output bis_pkg::ctrl_t                           ctrl_s2,
	output logic [FRAC_BITS-1:0]                     fx_s2,
	output logic [FRAC_BITS-1:0]                     fy_s2,
	output logic [AW-1:0]                            base_s2,
	output logic [AW-1:0]                            widx_s2,
	output logic [PIXEL_BITS-1:0]                    wdata_s2
);

	logic signed [bis_pkg::COORD_W-1:0] xi;
	logic signed [bis_pkg::COORD_W-1:0] yi;
	logic                               x_ok;
	logic                               y_ok;
	logic                               is_sample;
	logic                               wr_ok;
	logic [AW:0]                        base;

	always_comb begin
		xi        = x_s1 >>> FRAC_BITS;
		yi        = y_s1 >>> FRAC_BITS;
		x_ok      = !xi[bis_pkg::COORD_W-1] &&
			((18'(xi[bis_pkg::COORD_W-2:0]) + 18'd1) < 18'(wlim));
		y_ok      = !yi[bis_pkg::COORD_W-1] &&
			((18'(yi[bis_pkg::COORD_W-2:0]) + 18'd1) < 18'(hlim));
		is_sample = (op_s1 == bis_pkg::OP_SAMPLE);
		wr_ok     = (op_s1 == bis_pkg::OP_WRITE) && (32'(idx_s1) < 32'(DEPTH));
		base      = (AW+1)'(yi[bis_pkg::COORD_W-2:0]) * (AW+1)'(wlim)
			+ (AW+1)'(xi[bis_pkg::COORD_W-2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2.vld    <= vld_s1;
			ctrl_s2.sample <= is_sample;
			ctrl_s2.ok     <= is_sample && x_ok && y_ok;
			ctrl_s2.wr     <= wr_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s2    <= x_s1[FRAC_BITS-1:0];
			fy_s2    <= y_s1[FRAC_BITS-1:0];
			base_s2  <= base[AW-1:0];
			widx_s2  <= AW'(idx_s1);
			wdata_s2 <= PIXEL_BITS'($unsigned(value_s1));
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bis_blend.sv
`default_nettype none

module bis_blend #(
	parameter int FRAC_BITS  = 8,
	parameter int PIXEL_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire bis_pkg::ctrl_t                      ctrl_s2,
	input  wire logic [FRAC_BITS-1:0]                fx_s2,
	input  wire logic [FRAC_BITS-1:0]                fy_s2,
	input  wire logic signed [PIXEL_BITS-1:0]        v00,
	input  wire logic signed [PIXEL_BITS-1:0]        v01,
	input  wire logic signed [PIXEL_BITS-1:0]        v10,
	input  wire logic signed [PIXEL_BITS-1:0]        v11,
	output logic                                     out_vld_q,
	output logic signed [bis_pkg::VALUE_W-1:0]       value_q,
	output logic                                     svalid_q
);

	localparam int PW = PIXEL_BITS + FRAC_BITS + 2;
	localparam int TW = PW + 1;
	localparam int MW = TW + FRAC_BITS + 2;
	localparam int SW = MW + 1;
	localparam logic [FRAC_BITS:0]     ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0]   HALF = SW'(1) << (2 * FRAC_BITS - 1);

	bis_pkg::ctrl_t           ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6;
	logic [FRAC_BITS-1:0]     fx_s3, fy_s3, fy_s4, fy_s5;
	logic [FRAC_BITS:0]       sfx, sfy;
	logic signed [PW-1:0]     p00_s4, p01_s4, p10_s4, p11_s4;
	logic signed [TW-1:0]     top_s5, bot_s5;
	logic signed [MW-1:0]     mt_s6, mb_s6;
	logic signed [SW-1:0]     tot;
	logic signed [PIXEL_BITS-1:0] res;

	always_comb begin
		sfx = ONE - {1'b0, fx_s3};
		sfy = ONE - {1'b0, fy_s5};
		tot = SW'(mt_s6) + SW'(mb_s6) + HALF;
		res = tot[2*FRAC_BITS+PIXEL_BITS-1:2*FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3   <= '0;
			ctrl_s4   <= '0;
			ctrl_s5   <= '0;
			ctrl_s6   <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			ctrl_s3   <= ctrl_s2;
			ctrl_s4   <= ctrl_s3;
			ctrl_s5   <= ctrl_s4;
			ctrl_s6   <= ctrl_s5;
			out_vld_q <= ctrl_s6.vld && ctrl_s6.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
			p00_s4   <= v00 * $signed({1'b0, sfx});
			p01_s4   <= v01 * $signed({1'b0, fx_s3});
			p10_s4   <= v10 * $signed({1'b0, sfx});
			p11_s4   <= v11 * $signed({1'b0, fx_s3});
			fy_s4    <= fy_s3;
			top_s5   <= TW'(p00_s4) + TW'(p01_s4);
			bot_s5   <= TW'(p10_s4) + TW'(p11_s4);
			fy_s5    <= fy_s4;
			mt_s6    <= top_s5 * $signed({1'b0, sfy});
			mb_s6    <= bot_s5 * $signed({1'b0, fy_s5});
			value_q  <= ctrl_s6.ok ? bis_pkg::VALUE_W'(res) : '0;
			svalid_q <= ctrl_s6.ok;
		end
	end

endmodule

`default_nettype wire
